[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[hdl/fofd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fofd_pkg
// Types, constants and stencil tables for the fourth-order derivative line.
// ----------------------------------------------------------------------------
package fofd_pkg;

  // Field and storage sizes
  localparam int VARIABLES   = 4;
  localparam int SAMPLE_BITS = 24;
  localparam int VAR_W       = 2;
  localparam int TAPS        = 5;
  localparam int OUT_BITS    = 28;
  localparam int CNT_W       = 3;

  // Stencil weights fit in 7 signed bits; sum of |weights| is at most 2^7
  localparam int COEF_W      = 7;
  localparam int COEF_LOG2   = 7;
  localparam int PROD_W      = SAMPLE_BITS + COEF_W;
  localparam int SUM_W       = SAMPLE_BITS + COEF_LOG2 + 1;

  // Divide by 12: round by adding 6, drop two bits, then divide by 3
  // through a reciprocal multiply (exact for dividends below 2^32).
  localparam int ROUND_HALF  = 6;
  localparam int DIV_IN_W    = SUM_W - 2;
  localparam int RECIP_W     = 32;
  localparam logic [RECIP_W-1:0] RECIP3 = 32'hAAAA_AAAB;
  localparam int RECIP_SHIFT = 33;
  localparam int MUL_W       = DIV_IN_W + RECIP_W;
  localparam int Q_W         = MUL_W - RECIP_SHIFT;

  // Output saturation limits
  localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};
  localparam logic [Q_W-1:0] POS_LIM = Q_W'(OUT_MAX);
  localparam logic [Q_W-1:0] NEG_LIM = POS_LIM + Q_W'(1);

  // Point count saturates one past a full window
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TAPS);
  localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(TAPS + 1);

  // Kind of work handed from the window stage to the stencil stage
  typedef enum logic [1:0] {
    JOB_FIRST = 2'd0,   // line start: first, second, inner point
    JOB_INNER = 2'd1,   // one interior point
    JOB_END   = 2'd2,   // line end: inner, penultimate, last point
    JOB_SHORT = 2'd3    // line too short: single error result
  } job_kind_t;

  typedef enum logic [2:0] {
    STC_FIRST  = 3'd0,
    STC_SECOND = 3'd1,
    STC_INNER  = 3'd2,
    STC_PENULT = 3'd3,
    STC_LAST   = 3'd4
  } stencil_t;

  typedef logic [TAPS-1:0][SAMPLE_BITS-1:0] win_t;
  typedef logic [TAPS-1:0][COEF_W-1:0]      coef_row_t;

  typedef struct packed {
    logic             valid;
    job_kind_t        kind;
    logic [VAR_W-1:0] var_id;
    win_t             win;
  } job_t;

  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] value;
    logic [VAR_W-1:0]        var_id;
    logic                    last;
    logic                    err;
  } sum_t;

  // Stencil used for a given result slot of a job
  function automatic stencil_t pick_stencil(job_kind_t kind, logic [1:0] step);
    stencil_t sel;
    sel = STC_INNER;
    case (kind)
      JOB_FIRST: begin
        case (step)
          2'd0:    sel = STC_FIRST;
          2'd1:    sel = STC_SECOND;
          default: sel = STC_INNER;
        endcase
      end
      JOB_END: begin
        case (step)
          2'd0:    sel = STC_INNER;
          2'd1:    sel = STC_PENULT;
          default: sel = STC_LAST;
        endcase
      end
      default: sel = STC_INNER;
    endcase
    return sel;
  endfunction

  // Weights, element 0 applies to the oldest tap (listed newest first here)
  function automatic coef_row_t stencil_row(stencil_t sel);
    coef_row_t row;
    case (sel)
      STC_FIRST:  row = {-7'sd3,  7'sd16, -7'sd36,  7'sd48, -7'sd25};
      STC_SECOND: row = { 7'sd1, -7'sd6,   7'sd18, -7'sd10, -7'sd3};
      STC_INNER:  row = {-7'sd1,  7'sd8,   7'sd0,  -7'sd8,   7'sd1};
      STC_PENULT: row = { 7'sd3,  7'sd10, -7'sd18,  7'sd6,  -7'sd1};
      STC_LAST:   row = { 7'sd25, -7'sd48, 7'sd36, -7'sd16,  7'sd3};
      default:    row = '0;
    endcase
    return row;
  endfunction

endpackage

[hdl/fofd_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fofd_in_if
// Sample channel: valid/ready handshake with sample, variable and line end.
// ----------------------------------------------------------------------------
interface fofd_in_if;
  import fofd_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [VAR_W-1:0]              variable;
  logic                          line_end;

  modport source (output valid, sample, variable, line_end, input ready);
  modport sink   (input valid, sample, variable, line_end, output ready);
endinterface

[hdl/fofd_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fofd_out_if
// Result channel: valid/ready handshake with derivative and its tags.
// ----------------------------------------------------------------------------
interface fofd_out_if;
  import fofd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] derivative;
  logic [VAR_W-1:0]           result_variable;
  logic                       line_last;
  logic                       short_line_error;

  modport source (output valid, derivative, result_variable, line_last,
                  short_line_error, input ready);
  modport sink   (input valid, derivative, result_variable, line_last,
                  short_line_error, output ready);
endinterface

[hdl/fourth_order_first_derivative_line_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fourth_order_first_derivative_line_top
// Fourth-order finite-difference first derivative along a grid line.
// ----------------------------------------------------------------------------
// Samples of up to four interleaved variables stream in with their variable
// number and a line-end mark; each variable keeps its own five-sample window
// and point count. The fifth sample of a line yields three results (first,
// second and first interior point), each later sample one interior result,
// and the line's last sample three results (interior, second-to-last, last).
// Lines of five points or fewer yield one result with short_line_error set
// and derivative zero. A sample is taken every cycle while it yields at most
// one result and the output does not stall; one yielding three holds the
// input until its last result issues, as the stencil unit evaluates one
// five-tap sum per cycle while its sum register is free. Results pass the
// window, stencil sum, divide by 12 (reciprocal multiply), result registers.
// Rounding is to nearest, ties away from zero; outputs saturate to 28 bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fourth_order_first_derivative_line_top (
  input logic        clk,
  input logic        rst,
  fofd_in_if.sink    in_ch,
  fofd_out_if.source out_ch
);
  import fofd_pkg::*;

  job_t job;
  logic job_take;
  sum_t sum;
  logic sum_take;

  fofd_window u_window (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .job      (job),
    .job_take (job_take)
  );

  fofd_stencil u_stencil (
    .clk      (clk),
    .rst      (rst),
    .job      (job),
    .job_take (job_take),
    .sum      (sum),
    .sum_take (sum_take)
  );

  fofd_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .sum      (sum),
    .sum_take (sum_take),
    .out_ch   (out_ch)
  );

  // A pending job is never dropped before all its results are issued
  `ASSERT_NEXT(a_job_held, clk, rst, job.valid && !job_take, job.valid, "job lost before taken")

  // Every line end of a known variable produces a job
  `ASSERT_NEXT(a_end_job, clk, rst, in_ch.valid && in_ch.ready && in_ch.line_end && (int'(in_ch.variable) < VARIABLES), job.valid, "line end without job")

  // Error results carry a zero derivative and close the line
  `ASSERT_IMPL(a_err_zero, clk, rst, out_ch.valid && out_ch.short_line_error, (out_ch.derivative == '0) && out_ch.line_last, "bad short line result")

endmodule

[hdl/fofd_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fofd_window
// Per-variable five-sample windows and point counts; classifies each sample
// and loads a job register with the updated window.
// ----------------------------------------------------------------------------
module fofd_window (
  input  logic          clk,
  input  logic          rst,
  fofd_in_if.sink       in_ch,
  output fofd_pkg::job_t job,
  input  logic          job_take
);
  import fofd_pkg::*;

  // Window contents only reach a result after five fresh samples, so no reset
  win_t             win [VARIABLES];
  logic [CNT_W-1:0] cnt [VARIABLES];

  logic             accept;
  logic             var_ok;
  logic [CNT_W-1:0] cnt_next;
  win_t             win_next;
  job_kind_t        kind_next;
  logic             load;

  logic             job_valid;
  job_kind_t        job_kind;
  logic [VAR_W-1:0] job_var;
  win_t             job_win;

  assign in_ch.ready = !job_valid || job_take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign var_ok      = int'(in_ch.variable) < VARIABLES;

  // Shift the new sample in and classify the point
  always_comb begin
    for (int k = 0; k < TAPS - 1; k++) begin
      win_next[k] = win[in_ch.variable][k+1];
    end
    win_next[TAPS-1] = in_ch.sample;

    cnt_next = (cnt[in_ch.variable] >= CNT_SAT) ? CNT_SAT
                                                : cnt[in_ch.variable] + CNT_W'(1);
    kind_next = JOB_INNER;
    load      = 1'b0;
    if (in_ch.line_end) begin
      load      = 1'b1;
      kind_next = (cnt_next <= CNT_FULL) ? JOB_SHORT : JOB_END;
    end else if (cnt_next == CNT_FULL) begin
      load      = 1'b1;
      kind_next = JOB_FIRST;
    end else if (cnt_next == CNT_SAT) begin
      load      = 1'b1;
      kind_next = JOB_INNER;
    end
  end

  // Window and count update
  always_ff @(posedge clk) begin
    if (accept && var_ok) begin
      win[in_ch.variable] <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VARIABLES; i++) begin
        cnt[i] <= '0;
      end
    end else if (accept && var_ok) begin
      cnt[in_ch.variable] <= in_ch.line_end ? '0 : cnt_next;
    end
  end

  // Job register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept && var_ok && load) begin
      job_valid <= 1'b1;
    end else if (job_take) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && var_ok && load) begin
      job_kind <= kind_next;
      job_var  <= in_ch.variable;
      job_win  <= win_next;
    end
  end

  assign job = '{valid: job_valid, kind: job_kind, var_id: job_var, win: job_win};

endmodule

[hdl/fofd_stencil.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fofd_stencil
// Evaluates one weighted five-tap stencil sum per cycle while the sum
// register is free; a three-result job is stepped through three slots.
// ----------------------------------------------------------------------------
module fofd_stencil (
  input  logic           clk,
  input  logic           rst,
  input  fofd_pkg::job_t job,
  output logic           job_take,
  output fofd_pkg::sum_t sum,
  input  logic           sum_take
);
  import fofd_pkg::*;

  logic [1:0]               step;
  logic [1:0]               last_step;
  logic                     fire;
  logic                     at_last;
  coef_row_t                coefs;
  logic signed [PROD_W-1:0] wx;
  logic signed [PROD_W-1:0] cx;
  logic signed [PROD_W-1:0] pr;
  logic signed [SUM_W-1:0]  acc;

  logic                     sum_valid;
  logic signed [SUM_W-1:0]  sum_value;
  logic [VAR_W-1:0]         sum_var;
  logic                     sum_last;
  logic                     sum_err;

  // Result slot control
  assign last_step = (job.kind == JOB_FIRST || job.kind == JOB_END) ? 2'd2 : 2'd0;
  assign fire      = job.valid && (!sum_valid || sum_take);
  assign at_last   = (step == last_step);
  assign job_take  = fire && at_last;
  assign coefs     = stencil_row(pick_stencil(job.kind, step));

  // Weighted sum over the five taps
  always_comb begin
    acc = '0;
    wx  = '0;
    cx  = '0;
    pr  = '0;
    for (int k = 0; k < TAPS; k++) begin
      wx  = {{(PROD_W-SAMPLE_BITS){job.win[k][SAMPLE_BITS-1]}}, job.win[k]};
      cx  = {{(PROD_W-COEF_W){coefs[k][COEF_W-1]}}, coefs[k]};
      pr  = wx * cx;
      acc = acc + {{(SUM_W-PROD_W){pr[PROD_W-1]}}, pr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 2'd0;
    end else if (fire) begin
      step <= at_last ? 2'd0 : step + 2'd1;
    end
  end

  // Sum register
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (fire) begin
      sum_valid <= 1'b1;
    end else if (sum_take) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sum_value <= (job.kind == JOB_SHORT) ? '0 : acc;
      sum_var   <= job.var_id;
      sum_last  <= at_last && (job.kind == JOB_END || job.kind == JOB_SHORT);
      sum_err   <= (job.kind == JOB_SHORT);
    end
  end

  assign sum = '{valid: sum_valid, value: sum_value, var_id: sum_var,
                 last: sum_last, err: sum_err};

endmodule

[hdl/fofd_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fofd_scale
// Divides the stencil sum by 12 with round-half-away-from-zero, saturates
// to the output width and holds the result register.
// ----------------------------------------------------------------------------
module fofd_scale (
  input  logic           clk,
  input  logic           rst,
  input  fofd_pkg::sum_t sum,
  output logic           sum_take,
  fofd_out_if.source     out_ch
);
  import fofd_pkg::*;

  logic [SUM_W-1:0]         mag;
  logic [SUM_W-1:0]         mag_rnd;
  logic [DIV_IN_W-1:0]      quad;
  logic [MUL_W-1:0]         prod;

  logic                     a_valid;
  logic                     a_take;
  logic [MUL_W-1:0]         a_prod;
  logic                     a_neg;
  logic [VAR_W-1:0]         a_var;
  logic                     a_last;
  logic                     a_err;

  logic [Q_W-1:0]           q;
  logic signed [OUT_BITS-1:0] deriv_next;

  logic                     o_valid;
  logic signed [OUT_BITS-1:0] o_deriv;
  logic [VAR_W-1:0]         o_var;
  logic                     o_last;
  logic                     o_err;

  assign a_take   = a_valid && (!o_valid || out_ch.ready);
  assign sum_take = sum.valid && (!a_valid || a_take);

  // Magnitude plus half, divided by 4, times the reciprocal of 3
  assign mag     = sum.value[SUM_W-1] ? -sum.value : sum.value;
  assign mag_rnd = mag + SUM_W'(ROUND_HALF);
  assign quad    = mag_rnd[SUM_W-1:2];
  assign prod    = MUL_W'(quad) * MUL_W'(RECIP3);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (sum_take) begin
      a_valid <= 1'b1;
    end else if (a_take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_take) begin
      a_prod <= prod;
      a_neg  <= sum.value[SUM_W-1];
      a_var  <= sum.var_id;
      a_last <= sum.last;
      a_err  <= sum.err;
    end
  end

  // Quotient, sign restore and saturation
  assign q = a_prod[MUL_W-1:RECIP_SHIFT];

  always_comb begin
    if (!a_neg) begin
      deriv_next = (q > POS_LIM) ? OUT_MAX : q[OUT_BITS-1:0];
    end else begin
      deriv_next = (q > NEG_LIM) ? OUT_MIN : -q[OUT_BITS-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (a_take) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      o_deriv <= deriv_next;
      o_var   <= a_var;
      o_last  <= a_last;
      o_err   <= a_err;
    end
  end

  assign out_ch.valid            = o_valid;
  assign out_ch.derivative       = o_deriv;
  assign out_ch.result_variable  = o_var;
  assign out_ch.line_last        = o_last;
  assign out_ch.short_line_error = o_err;

endmodule
